// ===== rtl/pmct_pkg.sv =====
`timescale 1ns / 1ps

package pmct_pkg;

    localparam int PMCT_POSITION_BITS = 16;

    localparam int BYTE_BITS   = 8;
    localparam int LIMIT_BITS  = 16;
    localparam int DELTA_BITS  = 10;
    localparam int TDATA_BITS  = 40;
    localparam int TUSER_BITS  = 1;
    localparam int CFG_IDX_BITS = 1;

    localparam int CURSOR_MARGIN = 8;

    localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = LIMIT_BITS'(1024 - CURSOR_MARGIN);
    localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = LIMIT_BITS'(768 - CURSOR_MARGIN);

    localparam logic signed [DELTA_BITS-1:0] SIGN_WEIGHT = 10'sh100;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_LIMIT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PHASE_STATUS = 2'd0,
        PHASE_X      = 2'd1,
        PHASE_Y      = 2'd2
    } phase_t;

    typedef struct packed {
        logic                 complete;
        logic [BYTE_BITS-1:0] status;
        logic [BYTE_BITS-1:0] x_delta;
        logic [BYTE_BITS-1:0] y_delta;
    } pkt_t;

endpackage

// ===== rtl/pmct_framer.sv =====
`timescale 1ns / 1ps

module pmct_framer
    import pmct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [BYTE_BITS-1:0] data_byte,
    output pkt_t                 pkt
);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [BYTE_BITS-1:0] status_reg;
    logic [BYTE_BITS-1:0] x_delta_reg;

    // A status byte without its always-one bit is dropped and framing restarts.
    always_comb
    begin
        unique case (phase_reg)
            PHASE_X:
            begin
                phase_next = PHASE_Y;
            end
            PHASE_Y:
            begin
                phase_next = PHASE_STATUS;
            end
            default:
            begin
                phase_next = data_byte[3] ? PHASE_X : PHASE_STATUS;
            end
        endcase
    end

    always_comb
    begin
        pkt.complete = fire && (phase_reg == PHASE_Y);
        pkt.status   = status_reg;
        pkt.x_delta  = x_delta_reg;
        pkt.y_delta  = data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_STATUS;
            status_reg  <= '0;
            x_delta_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            if ((phase_reg != PHASE_X) && (phase_reg != PHASE_Y) && data_byte[3])
            begin
                status_reg <= data_byte;
            end
            if (phase_reg == PHASE_X)
            begin
                x_delta_reg <= data_byte;
            end
        end
    end

endmodule

// ===== rtl/pmct_axis_clamp.sv =====
`timescale 1ns / 1ps

module pmct_axis_clamp
    import pmct_pkg::*;
#(
    parameter int POSITION_BITS = PMCT_POSITION_BITS
)
(
    input  logic [POSITION_BITS-1:0]     pos,
    input  logic signed [DELTA_BITS-1:0] delta,
    input  logic [LIMIT_BITS-1:0]        limit,
    output logic [POSITION_BITS-1:0]     pos_new
);

    localparam int EXT_BITS = ((POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS) + 2;

    logic signed [EXT_BITS-1:0] pos_ext;
    logic signed [EXT_BITS-1:0] delta_ext;
    logic signed [EXT_BITS-1:0] limit_ext;
    logic signed [EXT_BITS-1:0] max_ext;
    logic signed [EXT_BITS-1:0] sum;
    logic signed [EXT_BITS-1:0] low_clamped;
    logic signed [EXT_BITS-1:0] lim_clamped;
    logic signed [EXT_BITS-1:0] max_clamped;

    always_comb
    begin
        pos_ext     = $signed(EXT_BITS'(pos));
        delta_ext   = EXT_BITS'(delta);
        limit_ext   = $signed(EXT_BITS'(limit));
        max_ext     = $signed(EXT_BITS'({POSITION_BITS{1'b1}}));
        sum         = pos_ext + delta_ext;
        low_clamped = (sum < 0) ? '0 : sum;
        lim_clamped = (low_clamped > limit_ext) ? limit_ext : low_clamped;
        max_clamped = (lim_clamped > max_ext) ? max_ext : lim_clamped;
        pos_new     = max_clamped[POSITION_BITS-1:0];
    end

endmodule

// ===== rtl/ps2_mouse_cursor_tracker_unit.sv =====
`timescale 1ns / 1ps

// PS/2 mouse cursor tracker.
// Mouse bytes enter on the s_ stream, one byte per beat. Every third byte of a
// well-framed packet produces one beat on the m_ stream carrying the cursor
// position and the latched button states; m_tuser flags a packet that was
// discarded for axis overflow, in which case position and buttons are the
// previous ones. Bad status bytes produce no beat.
// The cursor limits are set through the cfg_ write port; the user must write them
// only while the block is idle, which the block itself does not enforce. Index 0
// is the x limit and index 1 the y limit. A byte passes an input register and then
// the framing and clamp logic into the output register. One byte is taken every
// cycle unless the receiver stalls. When the receiver stalls, the result holds in
// the output register and one more byte waits in the input register before
// s_tready drops.
// Reset clears the framing, sets the position to the origin with all buttons
// released, and restores the limits to 1016 and 760.

module ps2_mouse_cursor_tracker_unit
    import pmct_pkg::*;
#(
    parameter int POSITION_BITS = PMCT_POSITION_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [BYTE_BITS-1:0]    s_tdata,   // [7:0] data_byte

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_BITS-1:0]   m_tdata,   // [15:0] cursor_x, [31:16] cursor_y,
                                               // [32] left_pressed, [33] right_pressed,
                                               // [34] middle_pressed, [39:35] zero
    output logic [TUSER_BITS-1:0]   m_tuser,   // [0] packet_dropped

    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LIMIT_BITS-1:0]   cfg_wdata
);

    localparam int OUT_EXT_BITS = (POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS;

    logic                     in_valid_reg;
    logic [BYTE_BITS-1:0]     in_byte_reg;
    logic                     advance;
    pkt_t                     pkt;

    logic [LIMIT_BITS-1:0]    x_limit_reg;
    logic [LIMIT_BITS-1:0]    y_limit_reg;
    logic [POSITION_BITS-1:0] pos_x_reg;
    logic [POSITION_BITS-1:0] pos_y_reg;
    logic [2:0]               buttons_reg;

    logic                     dropped;
    logic                     update;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [DELTA_BITS-1:0] dy_neg;
    logic [POSITION_BITS-1:0] pos_x_new;
    logic [POSITION_BITS-1:0] pos_y_new;
    logic [POSITION_BITS-1:0] pos_x_next;
    logic [POSITION_BITS-1:0] pos_y_next;
    logic [2:0]               buttons_next;
    logic [OUT_EXT_BITS-1:0]  x_ext;
    logic [OUT_EXT_BITS-1:0]  y_ext;

    logic                     m_tvalid_reg;
    logic [TDATA_BITS-1:0]    m_tdata_reg;
    logic [TUSER_BITS-1:0]    m_tuser_reg;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    pmct_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .data_byte (in_byte_reg),
        .pkt       (pkt)
    );

    always_comb
    begin
        dx      = $signed({2'b00, pkt.x_delta}) - (pkt.status[4] ? SIGN_WEIGHT : '0);
        dy      = $signed({2'b00, pkt.y_delta}) - (pkt.status[5] ? SIGN_WEIGHT : '0);
        dy_neg  = -dy;
        dropped = pkt.status[7] || pkt.status[6];
        update  = pkt.complete && !dropped;
    end

    pmct_axis_clamp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_clamp_x (
        .pos     (pos_x_reg),
        .delta   (dx),
        .limit   (x_limit_reg),
        .pos_new (pos_x_new)
    );

    pmct_axis_clamp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_clamp_y (
        .pos     (pos_y_reg),
        .delta   (dy_neg),
        .limit   (y_limit_reg),
        .pos_new (pos_y_new)
    );

    always_comb
    begin
        pos_x_next   = update ? pos_x_new : pos_x_reg;
        pos_y_next   = update ? pos_y_new : pos_y_reg;
        buttons_next = update ? pkt.status[2:0] : buttons_reg;
        x_ext        = OUT_EXT_BITS'(pos_x_next);
        y_ext        = OUT_EXT_BITS'(pos_y_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            buttons_reg <= '0;
        end
        else if (advance)
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            buttons_reg <= buttons_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == REG_X_LIMIT)
            begin
                x_limit_reg <= cfg_wdata;
            end
            if (cfg_index == REG_Y_LIMIT)
            begin
                y_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance && pkt.complete)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pkt.complete)
        begin
            m_tdata_reg <= {5'b00000, buttons_next[2], buttons_next[1], buttons_next[0],
                            y_ext[LIMIT_BITS-1:0], x_ext[LIMIT_BITS-1:0]};
            m_tuser_reg <= dropped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/pmct_checker.sv =====
`timescale 1ns / 1ps

module pmct_checker
    import pmct_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [TDATA_BITS-1:0]   m_tdata,
    input logic [TUSER_BITS-1:0]   m_tuser,
    input logic                    cfg_wen,
    input logic [CFG_IDX_BITS-1:0] cfg_index,
    input logic [LIMIT_BITS-1:0]   cfg_wdata
);

    logic [LIMIT_BITS-1:0] x_lim_reg;
    logic [LIMIT_BITS-1:0] y_lim_reg;
    logic [34:0]           last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lim_reg <= X_LIMIT_RESET;
            y_lim_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == REG_X_LIMIT)
            begin
                x_lim_reg <= cfg_wdata;
            end
            if (cfg_index == REG_Y_LIMIT)
            begin
                y_lim_reg <= cfg_wdata;
            end
        end
    end

    // Last delivered position and buttons; a dropped packet must repeat them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_reg <= m_tdata[34:0];
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] <= x_lim_reg)
        else $error("cursor x above its limit");

    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:16] <= y_lim_reg)
        else $error("cursor y above its limit");

    a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[34:0] == last_reg)
        else $error("dropped packet changed position or buttons");

endmodule

bind ps2_mouse_cursor_tracker_unit pmct_checker u_pmct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);

// ===== bench/cursor_tracker_checker.sv =====
`timescale 1ns / 1ps

module cursor_tracker_checker
    import pmct_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [BYTE_BITS-1:0]    s_tdata,

    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [TDATA_BITS-1:0]   m_tdata,
    input  logic [TUSER_BITS-1:0]   m_tuser,

    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LIMIT_BITS-1:0]   cfg_wdata,

    output int                      mismatch_count,
    output int                      reports_due
);

    localparam int ALWAYS_ONE_BIT = 3;
    localparam int X_SIGN_BIT     = 4;
    localparam int Y_SIGN_BIT     = 5;
    localparam int X_OVERFLOW_BIT = 6;
    localparam int Y_OVERFLOW_BIT = 7;
    localparam longint NEG_WEIGHT = 256;

    typedef struct {
        logic [15:0] cursor_x;
        logic [15:0] cursor_y;
        logic        left;
        logic        right;
        logic        middle;
        logic        dropped;
    } cursor_report_t;

    phase_t                        phase;
    logic [BYTE_BITS-1:0]          held_status;
    logic [BYTE_BITS-1:0]          held_x;
    logic [PMCT_POSITION_BITS-1:0] pos_x;
    logic [PMCT_POSITION_BITS-1:0] pos_y;
    logic [2:0]                    buttons;
    logic [LIMIT_BITS-1:0]         x_lim;
    logic [LIMIT_BITS-1:0]         y_lim;
    cursor_report_t                report_q[$];
    int                            errors;

    function automatic longint mouse_delta(input logic [7:0] low, input logic neg);
        return longint'(low) - (neg ? NEG_WEIGHT : 0);
    endfunction

    function automatic logic [PMCT_POSITION_BITS-1:0] move_axis(
        input logic [PMCT_POSITION_BITS-1:0] pos,
        input longint                        delta,
        input logic [LIMIT_BITS-1:0]         lim
    );
        longint sum;
        longint ceiling;
        ceiling = (longint'(1) << PMCT_POSITION_BITS) - 1;
        sum = longint'(pos) + delta;
        if (sum < 0)
            sum = 0;
        if (sum > longint'(lim))
            sum = longint'(lim);
        if (sum > ceiling)
            sum = ceiling;
        return sum[PMCT_POSITION_BITS-1:0];
    endfunction

    function automatic bit take_mouse_byte(input logic [7:0] b, output cursor_report_t rep);
        rep = '{default: '0};
        case (phase)
            PHASE_X:
            begin
                held_x = b;
                phase = PHASE_Y;
                return 1'b0;
            end
            PHASE_Y:
            begin
                phase = PHASE_STATUS;
                rep.dropped = held_status[X_OVERFLOW_BIT] | held_status[Y_OVERFLOW_BIT];
                if (!rep.dropped)
                begin
                    pos_x = move_axis(pos_x, mouse_delta(held_x, held_status[X_SIGN_BIT]),
                                      x_lim);
                    pos_y = move_axis(pos_y, -mouse_delta(b, held_status[Y_SIGN_BIT]),
                                      y_lim);
                    buttons = held_status[2:0];
                end
                rep.cursor_x = pos_x[15:0];
                rep.cursor_y = pos_y[15:0];
                rep.left     = buttons[0];
                rep.right    = buttons[1];
                rep.middle   = buttons[2];
                return 1'b1;
            end
            default:
            begin
                if (b[ALWAYS_ONE_BIT])
                begin
                    held_status = b;
                    phase = PHASE_X;
                end
                else
                begin
                    phase = PHASE_STATUS;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t rep;
        if (!rst_n)
        begin
            phase       = PHASE_STATUS;
            held_status = '0;
            held_x      = '0;
            pos_x       = '0;
            pos_y       = '0;
            buttons     = '0;
            x_lim       = X_LIMIT_RESET;
            y_lim       = Y_LIMIT_RESET;
            report_q.delete();
            errors      = 0;
            mismatch_count <= 0;
            reports_due    <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == REG_X_LIMIT)
                    x_lim = cfg_wdata;
                else if (cfg_index == REG_Y_LIMIT)
                    y_lim = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                if (take_mouse_byte(s_tdata, rep))
                    report_q.push_back(rep);
            end
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report with none expected: x=%0d y=%0d buttons=%b dropped=%b",
                           m_tdata[15:0], m_tdata[31:16], m_tdata[34:32], m_tuser[0]);
                    errors++;
                end
                else
                begin
                    rep = report_q.pop_front();
                    check_field("cursor_x", rep.cursor_x, m_tdata[15:0]);
                    check_field("cursor_y", rep.cursor_y, m_tdata[31:16]);
                    check_field("left_pressed", 16'(rep.left), 16'(m_tdata[32]));
                    check_field("right_pressed", 16'(rep.right), 16'(m_tdata[33]));
                    check_field("middle_pressed", 16'(rep.middle), 16'(m_tdata[34]));
                    check_field("tdata padding", 16'd0, 16'(m_tdata[39:35]));
                    check_field("packet_dropped", 16'(rep.dropped), 16'(m_tuser[0]));
                end
            end
            mismatch_count <= errors;
            reports_due    <= report_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pmct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_BYTES    = 115;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [BYTE_BITS-1:0]    s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]   m_tdata;
    logic [TUSER_BITS-1:0]   m_tuser;
    logic                    cfg_wen   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_X_LIMIT;
    logic [LIMIT_BITS-1:0]   cfg_wdata = '0;

    int mismatch_count;
    int reports_due;
    int src_idle_pct = 17;
    int snk_idle_pct = 69;
    int quiet_cycles = 0;

    ps2_mouse_cursor_tracker_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cursor_tracker_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no beat accepted for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(status);
        send_byte(dx);
        send_byte(dy);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [15:0] xl, input logic [15:0] yl);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_X_LIMIT;
        cfg_wdata <= xl;
        @(posedge clk);
        cfg_index <= REG_Y_LIMIT;
        cfg_wdata <= yl;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic mouse_traffic(input int count);
        int          sent;
        int          pick;
        logic [7:0]  status;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
            begin
                status = 8'($urandom);
                status[3] = 1'b1;
                if ($urandom_range(0, 9) != 0)
                    status[7:6] = 2'b00;
                send_packet(status, pick_delta(), pick_delta());
                sent += 3;
            end
            else if (pick < 90)
            begin
                status = 8'($urandom);
                status[3] = 1'b0;
                send_byte(status);
            end
            else
            begin
                send_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        int ph;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h1F, 8'h00, 8'h00);
        send_packet(8'h08, 8'hFF, 8'h00);
        send_packet(8'h28, 8'h00, 8'h00);
        send_packet(8'h3A, 8'hFF, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hF7);
        send_packet(8'h4F, 8'h12, 8'h34);
        send_packet(8'h8D, 8'hFF, 8'h80);
        send_packet(8'hC8, 8'h7F, 8'h01);
        wait_quiet();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_limits(16'hFFFF, 16'hFFFF);
                1: set_limits(16'd100, 16'd37);
                2: set_limits(16'd0, 16'd0);
                3: set_limits(X_LIMIT_RESET, Y_LIMIT_RESET);
                4: set_limits(16'($urandom), 16'($urandom));
                default: set_limits(16'($urandom_range(0, 2047)),
                                    16'($urandom_range(0, 2047)));
            endcase
            case (ph / 2)
                0:
                begin
                    src_idle_pct = 17;
                    snk_idle_pct = 69;
                end
                1:
                begin
                    src_idle_pct = 69;
                    snk_idle_pct = 17;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            mouse_traffic(PHASE_BYTES);
            wait_quiet();
        end

        if (reports_due != 0)
            $error("%0d reports never arrived", reports_due);
        if (mismatch_count == 0 && reports_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
